FILE: src/pbpi_pkg.sv
// Package for the bucketed postings index: default sizes, field widths,
// command, status and sequencer state codes. No dependencies.
package pbpi_pkg;

  localparam int MAX_RECORDS_DEF     = 1024;
  localparam int MAX_BUCKET_BITS_DEF = 10;
  localparam int KEY_BITS_DEF        = 32;

  localparam int HASH_W   = 64;
  localparam int CFG_W    = 4;
  localparam int STATUS_W = 3;

  localparam logic [CFG_W-1:0] BUCKET_BITS_RST = 4'd10;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_FINAL  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_BITS  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_BUILT = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_S_LOAD,
    ST_S_HOLD,
    ST_S_PROBE,
    ST_S_CMP,
    ST_S_PLACE,
    ST_F_RD,
    ST_F_CHK,
    ST_F_TAIL
  } state_t;

endpackage

FILE: src/prefix_bucket_postings_index.sv
// Bucketed postings index: record store, insertion sort, offset and postings build.
// Depends on pbpi_pkg.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, mode, hash_value, key_in,   | to block
//          | posting_index                                   |
//  out     | out_valid, out_stall, status, range_begin,      | from block
//          | range_end, key_out, total_postings              |
//  cfg     | cfg_we, cfg_data (bucket bits)                  | to block
//
// Append and error answers are registered from idle; lookup and read pass
// through ST_RESP (registered memory read). Finalize runs a sequencer over
// the record store: each record is loaded and placed by the insertion sort,
// then records are read to write postings and offsets, one offset per bucket
// boundary (2^bucket_bits + 1). in_stall is high while a word is in work or
// the output word is held by out_stall. Reset clears control state only; the
// memories hold nothing valid until written and no clearing pass runs.
module prefix_bucket_postings_index #(
  parameter int MAX_RECORDS     = pbpi_pkg::MAX_RECORDS_DEF,
  parameter int MAX_BUCKET_BITS = pbpi_pkg::MAX_BUCKET_BITS_DEF,
  parameter int KEY_BITS        = pbpi_pkg::KEY_BITS_DEF,
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pbpi_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [pbpi_pkg::HASH_W-1:0]   hash_value,
  input  logic [KEY_BITS-1:0]           key_in,
  input  logic [AW-1:0]                 posting_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pbpi_pkg::STATUS_W-1:0] status,
  output logic [CW-1:0]                 range_begin,
  output logic [CW-1:0]                 range_end,
  output logic [KEY_BITS-1:0]           key_out,
  output logic [CW-1:0]                 total_postings
);

  localparam int BW   = MAX_BUCKET_BITS;
  localparam int OW   = BW + 1;
  localparam int NOFF = (1 << BW) + 1;
  localparam int RW   = BW + KEY_BITS;
  localparam int SW   = $clog2(MAX_BUCKET_BITS + 1);
  localparam int HW   = pbpi_pkg::HASH_W;

  // memories
  logic [RW-1:0]       rec_mem  [MAX_RECORDS];
  logic [CW-1:0]       off_mem  [NOFF];
  logic [KEY_BITS-1:0] post_mem [MAX_RECORDS];

  logic                rec_we;
  logic [AW-1:0]       rec_waddr;
  logic [RW-1:0]       rec_wdata;
  logic [AW-1:0]       rec_raddr;
  logic [RW-1:0]       rec_q;
  logic                off_we;
  logic [OW-1:0]       off_waddr;
  logic [CW-1:0]       off_wdata;
  logic [OW-1:0]       off_ra0;
  logic [OW-1:0]       off_ra1;
  logic [CW-1:0]       off_q0;
  logic [CW-1:0]       off_q1;
  logic                post_we;
  logic [AW-1:0]       post_waddr;
  logic [KEY_BITS-1:0] post_wdata;
  logic [KEY_BITS-1:0] post_q;

  // control registers
  pbpi_pkg::state_t          state, state_next;
  pbpi_pkg::mode_t           resp_mode, resp_mode_next;
  logic [pbpi_pkg::CFG_W-1:0] bucket_bits;
  logic [pbpi_pkg::CFG_W-1:0] built_bits, built_bits_next;
  logic                      index_built, index_built_next;
  logic [CW-1:0]             rec_count, rec_count_next;
  logic [CW-1:0]             posting_total, posting_total_next;
  logic [CW-1:0]             i, i_next;
  logic [AW-1:0]             j, j_next;
  logic [CW-1:0]             kept, kept_next;
  logic [OW-1:0]             cb, cb_next;
  logic [RW-1:0]             cur, cur_next;
  logic [BW-1:0]             last_b, last_b_next;
  logic [KEY_BITS-1:0]       last_k, last_k_next;

  logic                          out_valid_next;
  logic [pbpi_pkg::STATUS_W-1:0] status_next;
  logic [CW-1:0]                 range_begin_next, range_end_next, total_postings_next;
  logic [KEY_BITS-1:0]           key_out_next;

  // datapath helpers
  pbpi_pkg::mode_t in_mode;
  logic            accept;
  logic            out_free;
  logic            bits_ok;
  logic [SW-1:0]   shamt;
  logic [SW-1:0]   shamt_b;
  logic [BW-1:0]   top_bits;
  logic [BW-1:0]   look_b;
  logic [BW-1:0]   cur_nb;
  logic [BW-1:0]   rd_nb;
  logic            rec_less;
  logic [OW-1:0]   nb;
  logic [CW-1:0]   i_inc;

  assign in_mode  = pbpi_pkg::mode_t'(mode);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pbpi_pkg::ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign bits_ok  = (bucket_bits != '0) &&
                    ({1'b0, bucket_bits} <= 5'(MAX_BUCKET_BITS));
  assign shamt    = SW'(MAX_BUCKET_BITS) - SW'(bucket_bits);
  assign shamt_b  = SW'(MAX_BUCKET_BITS) - SW'(built_bits);
  assign top_bits = hash_value[HW-1 -: BW];
  assign look_b   = top_bits >> shamt_b;
  assign off_ra0  = {1'b0, look_b};
  assign off_ra1  = off_ra0 + OW'(1);
  assign nb       = OW'(1) << bucket_bits;
  assign i_inc    = i + CW'(1);

  // narrow stored buckets to the active prefix width on the fly
  assign cur_nb   = cur[RW-1 -: BW] >> shamt;
  assign rd_nb    = rec_q[RW-1 -: BW] >> shamt;
  assign rec_less = {cur_nb, cur[KEY_BITS-1:0]} < {rd_nb, rec_q[KEY_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_q <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    off_q0 <= off_mem[off_ra0];
    off_q1 <= off_mem[off_ra1];
  end

  always_ff @(posedge clk) begin
    if (post_we) begin
      post_mem[post_waddr] <= post_wdata;
    end
    post_q <= post_mem[posting_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pbpi_pkg::ST_IDLE;
      out_valid     <= 1'b0;
      bucket_bits   <= pbpi_pkg::BUCKET_BITS_RST;
      built_bits    <= '0;
      index_built   <= 1'b0;
      rec_count     <= '0;
      posting_total <= '0;
    end else begin
      state         <= state_next;
      out_valid     <= out_valid_next;
      if (cfg_we) begin
        bucket_bits <= cfg_data;
      end
      built_bits    <= built_bits_next;
      index_built   <= index_built_next;
      rec_count     <= rec_count_next;
      posting_total <= posting_total_next;
    end
  end

  always_ff @(posedge clk) begin
    resp_mode      <= resp_mode_next;
    i              <= i_next;
    j              <= j_next;
    kept           <= kept_next;
    cb             <= cb_next;
    cur            <= cur_next;
    last_b         <= last_b_next;
    last_k         <= last_k_next;
    status         <= status_next;
    range_begin    <= range_begin_next;
    range_end      <= range_end_next;
    key_out        <= key_out_next;
    total_postings <= total_postings_next;
  end

  always_comb begin
    state_next          = state;
    resp_mode_next      = resp_mode;
    built_bits_next     = built_bits;
    index_built_next    = index_built;
    rec_count_next      = rec_count;
    posting_total_next  = posting_total;
    i_next              = i;
    j_next              = j;
    kept_next           = kept;
    cb_next             = cb;
    cur_next            = cur;
    last_b_next         = last_b;
    last_k_next         = last_k;
    out_valid_next      = out_valid && out_stall;
    status_next         = status;
    range_begin_next    = range_begin;
    range_end_next      = range_end;
    key_out_next        = key_out;
    total_postings_next = total_postings;
    rec_we              = 1'b0;
    rec_waddr           = i[AW-1:0];
    rec_wdata           = cur;
    rec_raddr           = i[AW-1:0];
    off_we              = 1'b0;
    off_waddr           = cb;
    off_wdata           = kept;
    post_we             = 1'b0;
    post_waddr          = kept[AW-1:0];
    post_wdata          = rec_q[KEY_BITS-1:0];

    case (state)
      pbpi_pkg::ST_IDLE: begin
        if (accept) begin
          // default answer; lookup, read and finalize overwrite it later
          out_valid_next      = 1'b1;
          status_next         = pbpi_pkg::STAT_OK;
          range_begin_next    = '0;
          range_end_next      = '0;
          key_out_next        = '0;
          total_postings_next = posting_total;
          resp_mode_next      = in_mode;
          case (in_mode)
            pbpi_pkg::MODE_APPEND: begin
              if (!bits_ok) begin
                status_next = pbpi_pkg::STAT_BAD_BITS;
              end else if (rec_count >= CW'(MAX_RECORDS)) begin
                status_next = pbpi_pkg::STAT_FULL;
              end else begin
                rec_we         = 1'b1;
                rec_waddr      = rec_count[AW-1:0];
                rec_wdata      = {top_bits, key_in};
                rec_count_next = rec_count + CW'(1);
              end
            end
            pbpi_pkg::MODE_FINAL: begin
              if (!bits_ok) begin
                status_next = pbpi_pkg::STAT_BAD_BITS;
              end else begin
                out_valid_next = 1'b0;
                kept_next      = '0;
                cb_next        = '0;
                if (rec_count <= CW'(1)) begin
                  i_next     = '0;
                  state_next = pbpi_pkg::ST_F_RD;
                end else begin
                  i_next     = CW'(1);
                  state_next = pbpi_pkg::ST_S_LOAD;
                end
              end
            end
            pbpi_pkg::MODE_LOOKUP: begin
              if (!index_built) begin
                status_next = pbpi_pkg::STAT_NOT_BUILT;
              end else begin
                out_valid_next = 1'b0;
                state_next     = pbpi_pkg::ST_RESP;
              end
            end
            pbpi_pkg::MODE_READ: begin
              if (!index_built) begin
                status_next = pbpi_pkg::STAT_NOT_BUILT;
              end else if ({1'b0, posting_index} >= posting_total) begin
                status_next = pbpi_pkg::STAT_RANGE;
              end else begin
                out_valid_next = 1'b0;
                state_next     = pbpi_pkg::ST_RESP;
              end
            end
            default: begin
              status_next = pbpi_pkg::STAT_OK;
            end
          endcase
        end
      end

      pbpi_pkg::ST_RESP: begin
        out_valid_next = 1'b1;
        if (resp_mode == pbpi_pkg::MODE_LOOKUP) begin
          range_begin_next = off_q0;
          range_end_next   = off_q1;
        end else begin
          key_out_next = post_q;
        end
        state_next = pbpi_pkg::ST_IDLE;
      end

      pbpi_pkg::ST_S_LOAD: begin
        state_next = pbpi_pkg::ST_S_HOLD;
      end

      pbpi_pkg::ST_S_HOLD: begin
        cur_next   = rec_q;
        j_next     = i[AW-1:0];
        state_next = pbpi_pkg::ST_S_PROBE;
      end

      pbpi_pkg::ST_S_PROBE: begin
        rec_raddr  = j - AW'(1);
        state_next = pbpi_pkg::ST_S_CMP;
      end

      pbpi_pkg::ST_S_CMP: begin
        rec_we    = 1'b1;
        rec_waddr = j;
        if (rec_less) begin
          // shift the larger record up one slot
          rec_wdata = rec_q;
          j_next    = j - AW'(1);
          state_next = (j == AW'(1)) ? pbpi_pkg::ST_S_PLACE : pbpi_pkg::ST_S_PROBE;
        end else begin
          rec_wdata = cur;
          i_next    = i_inc;
          if (i_inc == rec_count) begin
            i_next     = '0;
            state_next = pbpi_pkg::ST_F_RD;
          end else begin
            state_next = pbpi_pkg::ST_S_LOAD;
          end
        end
      end

      pbpi_pkg::ST_S_PLACE: begin
        rec_we    = 1'b1;
        rec_waddr = j;
        rec_wdata = cur;
        i_next    = i_inc;
        if (i_inc == rec_count) begin
          i_next     = '0;
          state_next = pbpi_pkg::ST_F_RD;
        end else begin
          state_next = pbpi_pkg::ST_S_LOAD;
        end
      end

      pbpi_pkg::ST_F_RD: begin
        state_next = (i == rec_count) ? pbpi_pkg::ST_F_TAIL : pbpi_pkg::ST_F_CHK;
      end

      pbpi_pkg::ST_F_CHK: begin
        if (kept != '0 && rd_nb == last_b && rec_q[KEY_BITS-1:0] == last_k) begin
          // drop exact duplicate
          i_next     = i_inc;
          state_next = pbpi_pkg::ST_F_RD;
        end else if (cb <= {1'b0, rd_nb}) begin
          // close buckets up to this record's bucket; hold the read word
          off_we  = 1'b1;
          cb_next = cb + OW'(1);
        end else begin
          post_we     = 1'b1;
          kept_next   = kept + CW'(1);
          last_b_next = rd_nb;
          last_k_next = rec_q[KEY_BITS-1:0];
          i_next      = i_inc;
          state_next  = pbpi_pkg::ST_F_RD;
        end
      end

      pbpi_pkg::ST_F_TAIL: begin
        if (cb <= nb) begin
          off_we  = 1'b1;
          cb_next = cb + OW'(1);
        end else begin
          posting_total_next  = kept;
          built_bits_next     = bucket_bits;
          index_built_next    = 1'b1;
          rec_count_next      = '0;
          out_valid_next      = 1'b1;
          status_next         = pbpi_pkg::STAT_OK;
          total_postings_next = kept;
          state_next          = pbpi_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = pbpi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
